>>> rtl/gtb_pkg.sv
// Shared types and constants of the greedy edge tour builder.
`default_nettype none
package gtb_pkg;

    localparam int MAX_CITIES_DEF = 256;
    localparam int MIN_CITIES     = 3;
    localparam int CITY_W         = 8;
    localparam int LEN_W          = 8;
    localparam int SUM_W          = 16;
    localparam int CNT_W          = 9;
    localparam int DEG_W          = 2;
    localparam int IN_DATA_W      = 24;
    localparam int OUT_DATA_W     = 32;

    localparam logic [DEG_W-1:0] DEG_LIMIT      = 2'd2;
    localparam logic [SUM_W-1:0] SUM_MAX        = 16'hFFFF;
    localparam logic [CNT_W-1:0] CITY_COUNT_RST = 9'd256;

    typedef enum logic [1:0] {
        V_ACCEPT = 2'd0,
        V_DEGREE = 2'd1,
        V_CYCLE  = 2'd2,
        V_DONE   = 2'd3
    } t_verdict;

    typedef struct packed {
        logic              restart;
        logic [LEN_W-1:0]  edge_length;
        logic [CITY_W-1:0] to_city;
        logic [CITY_W-1:0] from_city;
    } t_edge;

    typedef struct packed {
        logic [CNT_W-1:0] edges_taken;
        logic [SUM_W-1:0] tour_length;
        logic             tour_complete;
        t_verdict         verdict;
    } t_result;

endpackage
`default_nettype wire

>>> rtl/gtb_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module gtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> rtl/gtb_ctrl.sv
// Sequencer: city lookups, fragment relabel sweep, degree update and counters.
`default_nettype none
module gtb_ctrl #(
    parameter int MAX_CITIES = gtb_pkg::MAX_CITIES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [gtb_pkg::CNT_W-1:0]  i_city_count,
    input  wire logic                       i_edge_valid,
    output logic                            o_edge_ready,
    input  wire gtb_pkg::t_edge             i_edge,
    output logic                            o_res_valid,
    input  wire logic                       i_res_ready,
    output gtb_pkg::t_result                o_res
);
    import gtb_pkg::*;

    localparam int IDX_W = $clog2(MAX_CITIES);
    localparam int CTR_W = $clog2(MAX_CITIES + 1);
    localparam int NW    = (CTR_W > CNT_W) ? CTR_W : CNT_W;

    localparam logic [CTR_W-1:0] LAST_IDX = CTR_W'(MAX_CITIES - 1);
    localparam logic [CTR_W-1:0] END_IDX  = CTR_W'(MAX_CITIES);
    localparam logic [NW-1:0]    N_MIN    = NW'(MIN_CITIES);
    localparam logic [NW-1:0]    N_MAX    = NW'(MAX_CITIES);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RDA, S_RDB, S_CHK, S_SWP, S_UPA, S_UPB, S_FIN
    } t_state;

    t_state            r_state;
    t_edge             r_edge;
    logic              r_item;
    logic [CTR_W-1:0]  r_idx;
    logic              r_sv;
    logic [IDX_W-1:0]  r_sw_addr;
    logic [IDX_W-1:0]  r_keep;
    logic [IDX_W-1:0]  r_drop;
    logic [IDX_W-1:0]  r_lbl_a;
    logic [DEG_W-1:0]  r_deg_a;
    logic [DEG_W-1:0]  r_deg_b;
    logic [CNT_W-1:0]  r_acc;
    logic [SUM_W-1:0]  r_sum;
    logic              r_done;
    t_verdict          r_verdict;

    logic [NW-1:0]     cc_wide;
    logic [NW-1:0]     eff_n;
    logic              out_of_range;
    logic [IDX_W-1:0]  a_idx;
    logic [IDX_W-1:0]  b_idx;

    logic [IDX_W-1:0]  rd_addr;
    logic              lbl_we;
    logic [IDX_W-1:0]  lbl_waddr;
    logic [IDX_W-1:0]  lbl_wdata;
    logic [IDX_W-1:0]  lbl_rd;
    logic              deg_we;
    logic [IDX_W-1:0]  deg_waddr;
    logic [DEG_W-1:0]  deg_wdata;
    logic [DEG_W-1:0]  deg_rd;

    logic [IDX_W-1:0]  cmp_x;
    logic [IDX_W-1:0]  cmp_y;
    logic              cmp_eq;
    logic [SUM_W:0]    sum_ext;
    logic [SUM_W-1:0]  sum_sat;

    // Effective city count, saturated into the legal range.
    always_comb begin
        cc_wide = NW'(i_city_count);
        if (cc_wide < N_MIN) begin
            eff_n = N_MIN;
        end else if (cc_wide > N_MAX) begin
            eff_n = N_MAX;
        end else begin
            eff_n = cc_wide;
        end
    end

    assign out_of_range = (NW'(r_edge.from_city) >= eff_n) || (NW'(r_edge.to_city) >= eff_n);
    assign a_idx = IDX_W'(r_edge.from_city);
    assign b_idx = IDX_W'(r_edge.to_city);

    // Shared label comparator: fragment check, then every step of the sweep.
    always_comb begin
        if (r_state == S_SWP) begin
            cmp_x = lbl_rd;
            cmp_y = r_drop;
        end else begin
            cmp_x = r_lbl_a;
            cmp_y = lbl_rd;
        end
    end
    assign cmp_eq = (cmp_x == cmp_y);

    assign sum_ext = {1'b0, r_sum} + (SUM_W + 1)'(r_edge.edge_length);
    assign sum_sat = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];

    always_comb begin
        rd_addr   = a_idx;
        lbl_we    = 1'b0;
        lbl_waddr = r_sw_addr;
        lbl_wdata = r_keep;
        deg_we    = 1'b0;
        deg_waddr = a_idx;
        deg_wdata = r_deg_a + DEG_W'(1);
        unique case (r_state)
            S_CLR: begin
                lbl_we    = 1'b1;
                lbl_waddr = r_idx[IDX_W-1:0];
                lbl_wdata = r_idx[IDX_W-1:0];
                deg_we    = 1'b1;
                deg_waddr = r_idx[IDX_W-1:0];
                deg_wdata = '0;
            end
            S_RDB: begin
                rd_addr = b_idx;
            end
            S_SWP: begin
                rd_addr = r_idx[IDX_W-1:0];
                lbl_we  = r_sv && cmp_eq;
            end
            S_UPA: begin
                deg_we = 1'b1;
            end
            S_UPB: begin
                deg_we    = 1'b1;
                deg_waddr = b_idx;
                deg_wdata = r_deg_b + DEG_W'(1);
            end
            default: begin
            end
        endcase
    end

    gtb_ram #(.WIDTH(IDX_W), .DEPTH(MAX_CITIES)) u_lbl_ram (
        .i_clk   (i_clk),
        .i_we    (lbl_we),
        .i_waddr (lbl_waddr),
        .i_wdata (lbl_wdata),
        .i_raddr (rd_addr),
        .o_rdata (lbl_rd)
    );

    gtb_ram #(.WIDTH(DEG_W), .DEPTH(MAX_CITIES)) u_deg_ram (
        .i_clk   (i_clk),
        .i_we    (deg_we),
        .i_waddr (deg_waddr),
        .i_wdata (deg_wdata),
        .i_raddr (rd_addr),
        .o_rdata (deg_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_item    <= 1'b0;
            r_idx     <= '0;
            r_sv      <= 1'b0;
            r_acc     <= '0;
            r_sum     <= '0;
            r_done    <= 1'b0;
            r_verdict <= V_ACCEPT;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= r_item ? S_RDA : S_IDLE;
                    end else begin
                        r_idx <= r_idx + CTR_W'(1);
                    end
                end
                S_IDLE: begin
                    if (i_edge_valid) begin
                        r_edge <= i_edge;
                        r_item <= 1'b1;
                        r_idx  <= '0;
                        if (i_edge.restart) begin
                            r_acc   <= '0;
                            r_sum   <= '0;
                            r_done  <= 1'b0;
                            r_state <= S_CLR;
                        end else begin
                            r_state <= S_RDA;
                        end
                    end
                end
                S_RDA: begin
                    if (r_done) begin
                        r_verdict <= V_DONE;
                        r_state   <= S_FIN;
                    end else if (out_of_range) begin
                        r_verdict <= V_DEGREE;
                        r_state   <= S_FIN;
                    end else begin
                        r_state <= S_RDB;
                    end
                end
                S_RDB: begin
                    r_deg_a <= deg_rd;
                    r_lbl_a <= lbl_rd;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_deg_b <= deg_rd;
                    r_keep  <= r_lbl_a;
                    r_drop  <= lbl_rd;
                    r_idx   <= '0;
                    r_sv    <= 1'b0;
                    if ((r_deg_a >= DEG_LIMIT) || (deg_rd >= DEG_LIMIT)) begin
                        r_verdict <= V_DEGREE;
                        r_state   <= S_FIN;
                    end else if (r_edge.from_city == r_edge.to_city) begin
                        r_verdict <= V_CYCLE;
                        r_state   <= S_FIN;
                    end else if (cmp_eq) begin
                        // same fragment: only the edge that closes the full tour passes
                        if ((NW'(r_acc) + NW'(1)) == eff_n) begin
                            r_verdict <= V_ACCEPT;
                            r_done    <= 1'b1;
                            r_state   <= S_UPA;
                        end else begin
                            r_verdict <= V_CYCLE;
                            r_state   <= S_FIN;
                        end
                    end else begin
                        r_verdict <= V_ACCEPT;
                        r_state   <= S_SWP;
                    end
                end
                S_SWP: begin
                    // read one entry ahead, rewrite the previous one on a match
                    if (r_idx != END_IDX) begin
                        r_idx     <= r_idx + CTR_W'(1);
                        r_sw_addr <= r_idx[IDX_W-1:0];
                        r_sv      <= 1'b1;
                    end else begin
                        r_sv    <= 1'b0;
                        r_state <= S_UPA;
                    end
                end
                S_UPA: begin
                    r_state <= S_UPB;
                end
                S_UPB: begin
                    r_acc   <= r_acc + CNT_W'(1);
                    r_sum   <= sum_sat;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_edge_ready = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_FIN);

    always_comb begin
        o_res.verdict       = r_verdict;
        o_res.tour_complete = r_done;
        o_res.tour_length   = r_sum;
        o_res.edges_taken   = r_acc;
    end

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(lbl_we || deg_we))
        else $error("RAM write while idle");

    a_deg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (deg_we && (r_state != S_CLR)) |-> (deg_wdata <= DEG_LIMIT))
        else $error("degree update past limit");

    a_done_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (r_verdict == V_DONE)) |-> r_done)
        else $error("tour-complete verdict without done flag");

    a_sweep_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SWP) && (r_idx == END_IDX)) |-> r_sv)
        else $error("sweep ended without final write slot");

endmodule
`default_nettype wire

>>> rtl/greedy_edge_tour_builder.sv
// Top level of the greedy edge tour builder: stream ports, city count register, output word.
//
//  channel   | dir | word                                               | handshake
//  s_axis    | in  | tdata: from_city, to_city, edge_length; tuser: restart | tvalid/tready
//  m_axis    | out | tdata: verdict, tour_complete, tour_length, edges_taken | tvalid/tready
//  cfg       | in  | city_count, 9 bits                                 | i_cfg_we
//
//  A merge adds the relabel sweep of the label RAM, one entry per cycle. A restart word
//  adds a clearing pass of the label and degree RAMs. After reset the same clearing pass
//  runs with s_axis_tready low; cfg writes are taken throughout. A result waits in the
//  output register while the next edge is accepted and processed.
`default_nettype none
module greedy_edge_tour_builder #(
    parameter int MAX_CITIES = gtb_pkg::MAX_CITIES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] from_city, [15:8] to_city, [23:16] edge_length
    input  wire logic [gtb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] restart
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [1:0] verdict, [2] tour_complete, [18:3] tour_length, [27:19] edges_taken, [31:28] zero
    output logic      [gtb_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  wire logic                            i_cfg_we,
    input  wire logic [gtb_pkg::CNT_W-1:0]       i_cfg_wdata
);
    import gtb_pkg::*;

    localparam int RES_W = $bits(t_result);

    logic [CNT_W-1:0] r_city_count;
    logic             r_m_valid;
    t_result          r_m_res;

    t_edge            edge_in;
    logic             res_valid;
    logic             res_ready;
    t_result          res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_city_count <= CITY_COUNT_RST;
        end else if (i_cfg_we) begin
            r_city_count <= i_cfg_wdata;
        end
    end

    always_comb begin
        edge_in.from_city   = s_axis_tdata[CITY_W-1:0];
        edge_in.to_city     = s_axis_tdata[2*CITY_W-1:CITY_W];
        edge_in.edge_length = s_axis_tdata[2*CITY_W+LEN_W-1:2*CITY_W];
        edge_in.restart     = s_axis_tuser;
    end

    gtb_ctrl #(.MAX_CITIES(MAX_CITIES)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_city_count (r_city_count),
        .i_edge_valid (s_axis_tvalid),
        .o_edge_ready (s_axis_tready),
        .i_edge       (edge_in),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    // Output word register: load when empty or being drained.
    assign res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_m_res <= res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - RES_W){1'b0}}, r_m_res};

endmodule
`default_nettype wire
